// ===== sv/gdau_pkg.sv =====
`timescale 1ns / 1ps
// Package for the Gregorian date arithmetic unit: operation codes, controller
// commands, status struct and calendar helper functions. No dependencies.
package gdau_pkg;

   localparam int MAX_YEAR_DEFAULT = 9999;

   localparam logic [13:0] RESET_YEAR  = 14'd1970;
   localparam logic [3:0]  RESET_MONTH = 4'd1;
   localparam logic [4:0]  RESET_DAY   = 5'd1;

   localparam logic [2:0] OP_SET        = 3'd0;
   localparam logic [2:0] OP_ADD_DAYS   = 3'd1;
   localparam logic [2:0] OP_ADD_MONTHS = 3'd2;
   localparam logic [2:0] OP_ADD_YEARS  = 3'd3;
   localparam logic [2:0] OP_DIFF       = 3'd4;

   localparam logic signed [1:0] ORD_EARLIER = -2'sd1;
   localparam logic signed [1:0] ORD_EQUAL   = 2'sd0;
   localparam logic signed [1:0] ORD_LATER   = 2'sd1;

   localparam logic [21:0] DIST_MAX = 22'h3FFFFF;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_YS_STORED,
      CMD_DN_STORED,
      CMD_YS_GIVEN,
      CMD_DN_GIVEN,
      CMD_SEARCH_MID,
      CMD_SEARCH_CMP,
      CMD_MONTH_YS,
      CMD_MONTH_INIT,
      CMD_MONTH_STEP,
      CMD_MONTHS_T,
      CMD_MONTHS_Q,
      CMD_FINISH
   } cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic       search_done;
      logic       month_done;
      logic       rsp_busy;
   } stat_type;

   // Divisibility by 25 is tested with the modular inverse of 25.
   function automatic logic is_leap(input logic [13:0] y);
      logic [23:0] pr100;
      logic [19:0] pr400;
      logic        div4;
      logic        div100;
      logic        div400;
      pr100  = 24'(y[13:2]) * 24'd3113;
      pr400  = 20'(y[13:4]) * 20'd41;
      div4   = (y[1:0] == 2'd0);
      div100 = div4 && (pr100[11:0] <= 12'd163);
      div400 = (y[3:0] == 4'd0) && (pr400[9:0] <= 10'd40);
      return div4 && (!div100 || div400);
   endfunction

   function automatic logic [4:0] days_of(input logic [3:0] m, input logic leap);
      logic [4:0] d;
      unique case (m)
         4'd2: begin
            d = leap ? 5'd29 : 5'd28;
         end
         4'd4, 4'd6, 4'd9, 4'd11: begin
            d = 5'd30;
         end
         default: begin
            d = 5'd31;
         end
      endcase
      return d;
   endfunction

   function automatic logic [4:0] days_in(input logic [13:0] y, input logic [3:0] m);
      return days_of(m, is_leap(y));
   endfunction

   function automatic logic [8:0] month_start(input logic [3:0] m);
      logic [8:0] s;
      unique case (m)
         4'd2:    s = 9'd31;
         4'd3:    s = 9'd59;
         4'd4:    s = 9'd90;
         4'd5:    s = 9'd120;
         4'd6:    s = 9'd151;
         4'd7:    s = 9'd181;
         4'd8:    s = 9'd212;
         4'd9:    s = 9'd243;
         4'd10:   s = 9'd273;
         4'd11:   s = 9'd304;
         4'd12:   s = 9'd334;
         default: s = 9'd0;
      endcase
      return s;
   endfunction

   // Days from 0001-01-01 to the first day of year y. Division by 100 uses a
   // reciprocal that is exact for every 14-bit year.
   function automatic logic [22:0] year_start(input logic [13:0] y);
      logic [13:0] p;
      logic [26:0] m100;
      logic [26:0] m400;
      p    = y - 14'd1;
      m100 = 27'(p) * 27'd5243;
      m400 = 27'(p[13:2]) * 27'd5243;
      return 23'(p) * 23'd365 + 23'(p[13:2]) - 23'(m100[26:19]) + 23'(m400[26:19]);
   endfunction

   function automatic logic date_ok(input logic [13:0] y, input logic [3:0] m,
                                    input logic [4:0] d, input logic [13:0] max_y);
      return (y >= 14'd1) && (y <= max_y) && (m >= 4'd1) && (m <= 4'd12) &&
             (d >= 5'd1) && (d <= days_in(y, m));
   endfunction

endpackage

// ===== sv/gdau_if.sv =====
`timescale 1ns / 1ps
// Request and response channel interfaces of the date arithmetic unit.
// Stand-alone; no package dependency.
interface gdau_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         op;
   logic [13:0]        new_year;
   logic [3:0]         new_month;
   logic [4:0]         new_day;
   logic signed [22:0] amount;

   modport source (output valid, op, new_year, new_month, new_day, amount, input ready);
   modport sink (input valid, op, new_year, new_month, new_day, amount, output ready);
endinterface

interface gdau_rsp_if;
   logic              valid;
   logic              ready;
   logic [13:0]       cur_year;
   logic [3:0]        cur_month;
   logic [4:0]        cur_day;
   logic [21:0]       day_distance;
   logic signed [1:0] order;
   logic              accepted;

   modport source (output valid, cur_year, cur_month, cur_day, day_distance, order,
                   accepted, input ready);
   modport sink (input valid, cur_year, cur_month, cur_day, day_distance, order,
                 accepted, output ready);
endinterface

// ===== sv/gdau_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencing state machine of the date arithmetic unit.
// Depends on gdau_pkg for the command and status types.
module gdau_ctrl import gdau_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_DISPATCH, ST_YS_S, ST_DN_S, ST_YS_G, ST_DN_G, ST_MONTHS_T,
      ST_MONTHS_Q, ST_S_MID, ST_S_CMP, ST_M_YS, ST_M_INIT, ST_M_STEP, ST_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = CMD_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd      = CMD_LOAD;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (stat.op == OP_ADD_DAYS || stat.op == OP_DIFF) begin
               state_in = ST_YS_S;
            end else if (stat.op == OP_ADD_MONTHS) begin
               state_in = ST_MONTHS_T;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_YS_S: begin
            cmd      = CMD_YS_STORED;
            state_in = ST_DN_S;
         end
         ST_DN_S: begin
            cmd      = CMD_DN_STORED;
            state_in = (stat.op == OP_DIFF) ? ST_YS_G : ST_S_MID;
         end
         ST_YS_G: begin
            cmd      = CMD_YS_GIVEN;
            state_in = ST_DN_G;
         end
         ST_DN_G: begin
            cmd      = CMD_DN_GIVEN;
            state_in = ST_FINISH;
         end
         ST_MONTHS_T: begin
            cmd      = CMD_MONTHS_T;
            state_in = ST_MONTHS_Q;
         end
         ST_MONTHS_Q: begin
            cmd      = CMD_MONTHS_Q;
            state_in = ST_FINISH;
         end
         ST_S_MID: begin
            if (stat.search_done) begin
               state_in = ST_M_YS;
            end else begin
               cmd      = CMD_SEARCH_MID;
               state_in = ST_S_CMP;
            end
         end
         ST_S_CMP: begin
            cmd      = CMD_SEARCH_CMP;
            state_in = ST_S_MID;
         end
         ST_M_YS: begin
            cmd      = CMD_MONTH_YS;
            state_in = ST_M_INIT;
         end
         ST_M_INIT: begin
            cmd      = CMD_MONTH_INIT;
            state_in = ST_M_STEP;
         end
         ST_M_STEP: begin
            if (stat.month_done) begin
               state_in = ST_FINISH;
            end else begin
               cmd = CMD_MONTH_STEP;
            end
         end
         ST_FINISH: begin
            if (!stat.rsp_busy) begin
               cmd      = CMD_FINISH;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sv/gdau_datapath.sv =====
`timescale 1ns / 1ps
// Datapath of the date arithmetic unit: stored date, day-number arithmetic,
// year search, month walk and the response register. Depends on gdau_pkg.
module gdau_datapath import gdau_pkg::*; #(
   parameter int MaxYear = MAX_YEAR_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output stat_type           stat,
   input  logic [2:0]         req_op,
   input  logic [13:0]        req_new_year,
   input  logic [3:0]         req_new_month,
   input  logic [4:0]         req_new_day,
   input  logic signed [22:0] req_amount,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [13:0]        rsp_cur_year,
   output logic [3:0]         rsp_cur_month,
   output logic [4:0]         rsp_cur_day,
   output logic [21:0]        rsp_day_distance,
   output logic signed [1:0]  rsp_order,
   output logic               rsp_accepted
);

   localparam logic [13:0] MaxYr = 14'(MaxYear);
   localparam logic signed [24:0] DayLimit =
      $signed(25'(year_start(MaxYr)) + 25'd364 + 25'(is_leap(MaxYr)));
   localparam logic signed [24:0] MonthLimit = 25'(MaxYear * 12);
   localparam logic signed [24:0] YearLimit  = 25'(MaxYear);

   logic [13:0]        y_ff, ny_ff, lo_ff, hi_ff, mid_ff, q_ff;
   logic [3:0]         m_ff, nm_ff, mo_ff;
   logic [4:0]         d_ff, nd_ff;
   logic [2:0]         op_ff;
   logic signed [22:0] amt_ff;
   logic [22:0]        ys_ff, b_ff;
   logic signed [24:0] a_ff, t_ff;
   logic [8:0]         r_ff;
   logic               leap_ff;
   logic               rsp_valid_ff, rsp_accepted_ff;
   logic [13:0]        rsp_year_ff;
   logic [3:0]         rsp_month_ff;
   logic [4:0]         rsp_day_ff;
   logic [21:0]        rsp_dist_ff;
   logic signed [1:0]  rsp_order_ff;

   logic [24:0]        dn_stored;
   logic signed [24:0] a_in;
   logic [22:0]        dn_given;
   logic [14:0]        mid_sum;
   logic [4:0]         step_dim;
   logic [17:0]        ym1;
   logic signed [24:0] t_in;
   logic [31:0]        q_prod;
   logic signed [24:0] ysum;

   logic               fin_ok;
   logic [13:0]        fin_y;
   logic [3:0]         fin_m;
   logic [4:0]         fin_d;
   logic [21:0]        fin_dist;
   logic signed [1:0]  fin_ord;

   assign dn_stored = 25'(ys_ff) + 25'(month_start(m_ff)) + 25'(d_ff) - 25'd1 +
                      ((m_ff > 4'd2 && is_leap(y_ff)) ? 25'd1 : 25'd0);
   assign a_in      = $signed(dn_stored) +
                      ((op_ff == OP_ADD_DAYS) ? 25'(amt_ff) : 25'sd0);
   assign dn_given  = ys_ff + 23'(month_start(nm_ff)) + 23'(nd_ff) - 23'd1 +
                      ((nm_ff > 4'd2 && is_leap(ny_ff)) ? 23'd1 : 23'd0);
   assign mid_sum   = 15'(lo_ff) + 15'(hi_ff) + 15'd1;
   assign step_dim  = days_of(mo_ff, leap_ff);
   assign ym1       = 18'(y_ff - 14'd1);
   assign t_in      = $signed(25'({ym1, 3'b000}) + 25'({ym1, 2'b00}) + 25'(m_ff - 4'd1)) +
                      25'(amt_ff);
   assign q_prod    = 32'(t_ff[17:2]) * 32'd43691;
   assign ysum      = $signed({11'd0, y_ff}) + 25'(amt_ff);

   assign stat.op          = op_ff;
   assign stat.search_done = (lo_ff == hi_ff);
   assign stat.month_done  = !((mo_ff < 4'd12) && (r_ff >= 9'(step_dim)));
   assign stat.rsp_busy    = rsp_valid_ff && !rsp_ready;

   always_comb begin
      logic [17:0] q12;
      logic [3:0]  rem;
      logic [13:0] ty;
      logic [3:0]  tm;
      logic [4:0]  dim;
      logic [22:0] a_u;
      logic [22:0] diff;
      q12      = 18'({q_ff, 3'b000}) + 18'({q_ff, 2'b00});
      rem      = 4'(t_ff[17:0] - q12);
      ty       = y_ff;
      tm       = m_ff;
      dim      = 5'd31;
      a_u      = 23'(a_ff);
      diff     = 23'd0;
      fin_ok   = 1'b0;
      fin_y    = y_ff;
      fin_m    = m_ff;
      fin_d    = d_ff;
      fin_dist = 22'd0;
      fin_ord  = ORD_EQUAL;
      unique case (op_ff)
         OP_SET: begin
            if (date_ok(ny_ff, nm_ff, nd_ff, MaxYr)) begin
               fin_ok = 1'b1;
               fin_y  = ny_ff;
               fin_m  = nm_ff;
               fin_d  = nd_ff;
            end
         end
         OP_ADD_DAYS: begin
            if (a_ff >= 25'sd0 && a_ff <= DayLimit) begin
               fin_ok = 1'b1;
               fin_y  = lo_ff;
               fin_m  = mo_ff;
               fin_d  = 5'(r_ff) + 5'd1;
            end
         end
         OP_ADD_MONTHS: begin
            ty  = q_ff + 14'd1;
            tm  = rem + 4'd1;
            dim = days_in(ty, tm);
            if (t_ff >= 25'sd0 && t_ff < MonthLimit) begin
               fin_ok = 1'b1;
               fin_y  = ty;
               fin_m  = tm;
               fin_d  = (d_ff > dim) ? dim : d_ff;
            end
         end
         OP_ADD_YEARS: begin
            ty  = ysum[13:0];
            dim = days_in(ty, m_ff);
            if (ysum >= 25'sd1 && ysum <= YearLimit) begin
               fin_ok = 1'b1;
               fin_y  = ty;
               fin_d  = (d_ff > dim) ? dim : d_ff;
            end
         end
         OP_DIFF: begin
            if (date_ok(ny_ff, nm_ff, nd_ff, MaxYr)) begin
               fin_ok = 1'b1;
               if (a_u > b_ff) begin
                  diff    = a_u - b_ff;
                  fin_ord = ORD_LATER;
               end else if (a_u < b_ff) begin
                  diff    = b_ff - a_u;
                  fin_ord = ORD_EARLIER;
               end
               fin_dist = diff[22] ? DIST_MAX : diff[21:0];
            end
         end
         default: begin
            fin_ok = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         y_ff         <= RESET_YEAR;
         m_ff         <= RESET_MONTH;
         d_ff         <= RESET_DAY;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && cmd != CMD_FINISH) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (cmd)
            CMD_NONE: begin
            end
            CMD_LOAD: begin
               op_ff  <= req_op;
               ny_ff  <= req_new_year;
               nm_ff  <= req_new_month;
               nd_ff  <= req_new_day;
               amt_ff <= req_amount;
            end
            CMD_YS_STORED: begin
               ys_ff <= year_start(y_ff);
            end
            CMD_DN_STORED: begin
               a_ff  <= a_in;
               lo_ff <= 14'd1;
               hi_ff <= MaxYr;
            end
            CMD_YS_GIVEN: begin
               ys_ff <= year_start(ny_ff);
            end
            CMD_DN_GIVEN: begin
               b_ff <= dn_given;
            end
            CMD_SEARCH_MID: begin
               mid_ff <= mid_sum[14:1];
               ys_ff  <= year_start(mid_sum[14:1]);
            end
            CMD_SEARCH_CMP: begin
               if ($signed({2'b00, ys_ff}) <= a_ff) begin
                  lo_ff <= mid_ff;
               end else begin
                  hi_ff <= mid_ff - 14'd1;
               end
            end
            CMD_MONTH_YS: begin
               ys_ff   <= year_start(lo_ff);
               leap_ff <= is_leap(lo_ff);
            end
            CMD_MONTH_INIT: begin
               r_ff  <= 9'(a_ff - $signed({2'b00, ys_ff}));
               mo_ff <= 4'd1;
            end
            CMD_MONTH_STEP: begin
               r_ff  <= r_ff - 9'(step_dim);
               mo_ff <= mo_ff + 4'd1;
            end
            CMD_MONTHS_T: begin
               t_ff <= t_in;
            end
            CMD_MONTHS_Q: begin
               q_ff <= 14'(q_prod[31:17]);
            end
            CMD_FINISH: begin
               y_ff            <= fin_y;
               m_ff            <= fin_m;
               d_ff            <= fin_d;
               rsp_valid_ff    <= 1'b1;
               rsp_accepted_ff <= fin_ok;
               rsp_year_ff     <= fin_y;
               rsp_month_ff    <= fin_m;
               rsp_day_ff      <= fin_d;
               rsp_dist_ff     <= fin_dist;
               rsp_order_ff    <= fin_ord;
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_cur_year     = rsp_year_ff;
   assign rsp_cur_month    = rsp_month_ff;
   assign rsp_cur_day      = rsp_day_ff;
   assign rsp_day_distance = rsp_dist_ff;
   assign rsp_order        = rsp_order_ff;
   assign rsp_accepted     = rsp_accepted_ff;

endmodule

// ===== sv/gregorian_date_arithmetic_unit.sv =====
`timescale 1ns / 1ps
// Top level of the Gregorian date arithmetic unit.
// Depends on gdau_pkg, gdau_if, gdau_ctrl and gdau_datapath.
//
// The unit holds one proleptic Gregorian date and applies one operation per
// request beat on req_bus: set, add days, add months, add years or difference.
// Every request produces exactly one response beat on rsp_bus carrying the
// stored date after the operation, the day distance and ordering for a
// difference, and an accepted flag that is low for an invalid date, an unused
// operation code or a result year outside 1 to MaxYear.
// One request is worked on at a time; req_bus.ready is high only while the
// unit waits for work. Set, add years and unused codes go from dispatch
// straight to the response; add months first forms the month index and its
// quotient by 12, difference the day numbers of both dates. Add days runs
// a binary search for the year over 1 to MaxYear (up to 14 steps for 9999)
// and then a month walk within that year before the response is written.
// The response sits in an output register, so the next request is taken
// while a response still waits; a stalled receiver holds the unit only when
// the following response is ready to be written.
// Synchronous reset loads 1970-01-01 and drops any pending response.
module gregorian_date_arithmetic_unit import gdau_pkg::*; #(
   parameter int MaxYear = MAX_YEAR_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   gdau_req_if.sink   req_bus,
   gdau_rsp_if.source rsp_bus
);

   cmd_type  cmd;
   stat_type stat;

   // The controller only sequences; all arithmetic and storage live in the
   // datapath, so the two meet at the command and status buses alone.
   gdau_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   gdau_datapath #(
      .MaxYear (MaxYear)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_op           (req_bus.op),
      .req_new_year     (req_bus.new_year),
      .req_new_month    (req_bus.new_month),
      .req_new_day      (req_bus.new_day),
      .req_amount       (req_bus.amount),
      .rsp_valid        (rsp_bus.valid),
      .rsp_ready        (rsp_bus.ready),
      .rsp_cur_year     (rsp_bus.cur_year),
      .rsp_cur_month    (rsp_bus.cur_month),
      .rsp_cur_day      (rsp_bus.cur_day),
      .rsp_day_distance (rsp_bus.day_distance),
      .rsp_order        (rsp_bus.order),
      .rsp_accepted     (rsp_bus.accepted)
   );

endmodule

// ===== verif/gregorian_date_arithmetic_unit_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the Gregorian date arithmetic unit: directed and
// random requests, random idling on both channels, checks against a date model.
// Depends on gdau_pkg, gdau_if and the gregorian_date_arithmetic_unit RTL.
module gregorian_date_arithmetic_unit_test;
   import gdau_pkg::OP_SET;
   import gdau_pkg::OP_ADD_DAYS;
   import gdau_pkg::OP_ADD_MONTHS;
   import gdau_pkg::OP_ADD_YEARS;
   import gdau_pkg::OP_DIFF;
   import gdau_pkg::ORD_EARLIER;
   import gdau_pkg::ORD_EQUAL;
   import gdau_pkg::ORD_LATER;

   // Codes the unit does not implement; they must be answered and rejected.
   localparam logic [2:0] OP_SPARE_A = 3'd5;
   localparam logic [2:0] OP_SPARE_C = 3'd7;

   localparam int         TOP_YEAR  = 9999;
   localparam longint     DIST_CAP  = 4194303;
   localparam int         RANDOM_BEATS = 200;

   typedef struct {
      logic [2:0]         op;
      logic [13:0]        year;
      logic [3:0]         month;
      logic [4:0]         day;
      logic signed [22:0] amount;
   } date_req_t;

   typedef struct {
      logic [13:0]       year;
      logic [3:0]        month;
      logic [4:0]        day;
      logic [21:0]       distance;
      logic signed [1:0] ord;
      logic              ok;
   } date_rsp_t;

   // Calendar model of the unit plus the queue of responses still owed.
   class date_scoreboard;
      longint    held_y;
      longint    held_m;
      longint    held_d;
      date_rsp_t owed[$];
      int        errors;
      int        checked;
      int        rejects;

      function new();
         held_y  = 1970;
         held_m  = 1;
         held_d  = 1;
         errors  = 0;
         checked = 0;
         rejects = 0;
      endfunction

      function bit leap(longint y);
         return (y % 4 == 0 && y % 100 != 0) || y % 400 == 0;
      endfunction

      function longint month_len(longint y, longint m);
         case (m)
            2: begin
               return leap(y) ? 29 : 28;
            end
            4, 6, 9, 11: begin
               return 30;
            end
            default: begin
               return 31;
            end
         endcase
      endfunction

      function bit valid_date(longint y, longint m, longint d);
         if (y < 1 || y > TOP_YEAR || m < 1 || m > 12) begin
            return 0;
         end
         return d >= 1 && d <= month_len(y, m);
      endfunction

      function longint first_day_of_year(longint y);
         longint p;
         p = y - 1;
         return 365 * p + p / 4 - p / 100 + p / 400;
      endfunction

      function longint serial_day(longint y, longint m, longint d);
         longint n;
         n = first_day_of_year(y) + d - 1;
         for (longint k = 1; k < m; k++) begin
            n += month_len(y, k);
         end
         return n;
      endfunction

      function void load_serial_day(longint n);
         longint y;
         longint m;
         longint r;
         y = n * 400 / 146097 + 1;
         if (y < 1) begin
            y = 1;
         end
         while (first_day_of_year(y + 1) <= n) begin
            y++;
         end
         while (y > 1 && first_day_of_year(y) > n) begin
            y--;
         end
         r = n - first_day_of_year(y);
         m = 1;
         while (m < 12 && r >= month_len(y, m)) begin
            r -= month_len(y, m);
            m++;
         end
         held_y = y;
         held_m = m;
         held_d = r + 1;
      endfunction

      // Calendar step; the day is clamped to the length of the target month.
      function bit step_calendar(longint y, longint m);
         if (y < 1 || y > TOP_YEAR) begin
            return 0;
         end
         held_y = y;
         held_m = m;
         if (held_d > month_len(y, m)) begin
            held_d = month_len(y, m);
         end
         return 1;
      endfunction

      function void note_request(date_req_t q);
         date_rsp_t e;
         longint    amt;
         longint    a;
         longint    b;
         longint    t;
         amt        = q.amount;
         e.ok       = 0;
         e.distance = '0;
         e.ord      = ORD_EQUAL;
         case (q.op)
            OP_SET: begin
               if (valid_date(q.year, q.month, q.day)) begin
                  held_y = q.year;
                  held_m = q.month;
                  held_d = q.day;
                  e.ok   = 1;
               end
            end
            OP_ADD_DAYS: begin
               a = serial_day(held_y, held_m, held_d) + amt;
               if (a >= 0 && a <= serial_day(TOP_YEAR, 12, 31)) begin
                  load_serial_day(a);
                  e.ok = 1;
               end
            end
            OP_ADD_MONTHS: begin
               t = (held_y - 1) * 12 + held_m - 1 + amt;
               if (t >= 0) begin
                  e.ok = step_calendar(t / 12 + 1, t % 12 + 1);
               end
            end
            OP_ADD_YEARS: begin
               e.ok = step_calendar(held_y + amt, held_m);
            end
            OP_DIFF: begin
               if (valid_date(q.year, q.month, q.day)) begin
                  a = serial_day(held_y, held_m, held_d);
                  b = serial_day(q.year, q.month, q.day);
                  t = a > b ? a - b : b - a;
                  e.distance = 22'(t > DIST_CAP ? DIST_CAP : t);
                  e.ord  = a > b ? ORD_LATER : (a < b ? ORD_EARLIER : ORD_EQUAL);
                  e.ok   = 1;
               end
            end
            default: begin
            end
         endcase
         e.year  = 14'(held_y);
         e.month = 4'(held_m);
         e.day   = 5'(held_d);
         owed.push_back(e);
      endfunction

      function void compare_field(string name, longint want, longint got);
         if (want != got) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         end
      endfunction

      function void check_response(date_rsp_t r);
         date_rsp_t e;
         if (owed.size() == 0) begin
            errors++;
            $display("%0t ns: response beat with nothing outstanding, year %0d", $time,
                     r.year);
            return;
         end
         e = owed.pop_front();
         checked++;
         if (!e.ok) begin
            rejects++;
         end
         compare_field("cur_year", e.year, r.year);
         compare_field("cur_month", e.month, r.month);
         compare_field("cur_day", e.day, r.day);
         compare_field("day_distance", e.distance, r.distance);
         compare_field("order", e.ord, r.ord);
         compare_field("accepted", e.ok, r.ok);
      endfunction
   endclass

   logic clock;
   logic reset;

   gdau_req_if req_bus ();
   gdau_rsp_if rsp_bus ();

   gregorian_date_arithmetic_unit u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source)
   );

   date_scoreboard date_board = new();
   bit             hold_off_request;
   int             op_beats[8];

   initial begin
      clock = 1'b0;
      forever begin
         #6 clock = ~clock;
      end
   end

   // Gap lengths are mostly zero or short, with the occasional long pause.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 50) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(3, 1);
      end
      return $urandom_range(40, 10);
   endfunction

   function automatic date_req_t make_req(logic [2:0] op, int y, int m, int d, int amt);
      date_req_t q;
      q.op     = op;
      q.year   = 14'(y);
      q.month  = 4'(m);
      q.day    = 5'(d);
      q.amount = 23'(amt);
      return q;
   endfunction

   // Random requests are mostly well formed; the rest is raw noise on all
   // fields, which also covers the unused codes and every bit of each field.
   function automatic date_req_t random_req();
      date_req_t q;
      int        r;
      q.op     = 3'($urandom_range(4));
      q.year   = 14'($urandom_range(TOP_YEAR, 1));
      q.month  = 4'($urandom_range(12, 1));
      q.day    = 5'($urandom_range(int'(date_board.month_len(q.year, q.month)), 1));
      r        = $urandom_range(99);
      if ($urandom_range(9) == 0) begin
         q.amount = 23'($urandom);
      end else if (q.op == OP_ADD_DAYS) begin
         q.amount = 23'($urandom_range(800) - 400);
         if ($urandom_range(3) == 0) begin
            q.amount = 23'($urandom_range(2000000) - 1000000);
         end
      end else if (q.op == OP_ADD_MONTHS) begin
         q.amount = 23'($urandom_range(60) - 30);
      end else begin
         q.amount = 23'($urandom_range(100) - 50);
      end
      if (r >= 90) begin
         q.op     = 3'($urandom);
         q.year   = 14'($urandom);
         q.month  = 4'($urandom);
         q.day    = 5'($urandom);
         q.amount = 23'($urandom);
      end
      return q;
   endfunction

   task automatic send_beat(date_req_t q);
      int gap;
      req_bus.valid     <= 1'b1;
      req_bus.op        <= q.op;
      req_bus.new_year  <= q.year;
      req_bus.new_month <= q.month;
      req_bus.new_day   <= q.day;
      req_bus.amount    <= q.amount;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
      date_board.note_request(q);
      op_beats[q.op]++;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_outstanding();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (date_board.owed.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Response side: random ready, with a long hold-off on request.
   initial begin
      date_rsp_t r;
      rsp_bus.ready <= 1'b0;
      forever begin
         if (hold_off_request) begin
            hold_off_request = 0;
            rsp_bus.ready <= 1'b0;
            repeat (300) @(posedge clock);
         end
         if ($urandom_range(30) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(40, 10)) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= ($urandom_range(3) != 0) || ($urandom_range(7) == 0 ? 0 : 1);
         end
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready) begin
            r.year     = rsp_bus.cur_year;
            r.month    = rsp_bus.cur_month;
            r.day      = rsp_bus.cur_day;
            r.distance = rsp_bus.day_distance;
            r.ord      = rsp_bus.order;
            r.ok       = rsp_bus.accepted;
            date_board.check_response(r);
         end
      end
   end

   initial begin
      #5ms;
      $display("tb: failure");
      $finish;
   end

   initial begin
      int settle;
      hold_off_request  = 0;
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.op        = OP_SET;
      req_bus.new_year  = '0;
      req_bus.new_month = '0;
      req_bus.new_day   = '0;
      req_bus.amount    = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: reset date, invalid sets, range edges, clamping,
      // amount extremes, zero amounts, unused codes and invalid compares.
      send_beat(make_req(OP_DIFF, 1970, 1, 1, 0));
      send_beat(make_req(OP_SET, 0, 1, 1, 0));
      send_beat(make_req(OP_SET, 16383, 15, 31, 0));
      send_beat(make_req(OP_SET, 2023, 2, 29, 0));
      send_beat(make_req(OP_SET, 2023, 4, 31, 0));
      send_beat(make_req(OP_SET, 2023, 13, 0, 0));
      send_beat(make_req(OP_SET, 9999, 12, 31, 0));
      send_beat(make_req(OP_ADD_DAYS, 0, 0, 0, 1));
      send_beat(make_req(OP_DIFF, 1, 1, 1, 0));
      send_beat(make_req(OP_ADD_YEARS, 0, 0, 0, 4194303));
      send_beat(make_req(OP_SET, 1, 1, 1, 0));
      send_beat(make_req(OP_ADD_DAYS, 0, 0, 0, -1));
      send_beat(make_req(OP_ADD_MONTHS, 0, 0, 0, -4194304));
      send_beat(make_req(OP_ADD_DAYS, 0, 0, 0, 3652058));
      send_beat(make_req(OP_SET, 2000, 1, 31, 0));
      send_beat(make_req(OP_ADD_MONTHS, 0, 0, 0, 1));
      send_beat(make_req(OP_SET, 2000, 2, 29, 0));
      send_beat(make_req(OP_ADD_YEARS, 0, 0, 0, 1));
      send_beat(make_req(OP_SET, 2024, 5, 31, 0));
      send_beat(make_req(OP_ADD_MONTHS, 0, 0, 0, -1));
      send_beat(make_req(OP_ADD_DAYS, 0, 0, 0, 0));
      send_beat(make_req(OP_ADD_YEARS, 0, 0, 0, 0));
      send_beat(make_req(OP_DIFF, 2024, 2, 30, 0));
      send_beat(make_req(OP_SPARE_A, 1999, 3, 3, 7));
      send_beat(make_req(OP_SPARE_C, 16383, 15, 31, -1));

      // The sender stops until the unit has answered everything.
      drain_outstanding();

      for (int i = 0; i < RANDOM_BEATS; i++) begin
         // Early on the receiver stalls for a long stretch while requests keep
         // coming, so the output register fills and the input backs up.
         if (i == 20) begin
            hold_off_request = 1;
         end
         if (i == 100) begin
            drain_outstanding();
         end
         send_beat(random_req());
      end
      req_bus.valid <= 1'b0;

      settle = 0;
      while (date_board.owed.size() != 0 && settle < 100000) begin
         @(posedge clock);
         settle++;
      end
      repeat (100) @(posedge clock);

      $display("run: %0d responses checked, %0d rejected by the unit", date_board.checked,
               date_board.rejects);
      $display("run: set %0d, days %0d, months %0d, years %0d, diff %0d, spare %0d",
               op_beats[0], op_beats[1], op_beats[2], op_beats[3], op_beats[4],
               op_beats[5] + op_beats[6] + op_beats[7]);
      if (date_board.errors == 0 && date_board.owed.size() == 0) begin
         $display("tb: success");
      end else begin
         if (date_board.owed.size() != 0) begin
            $display("%0t ns: %0d responses never arrived", $time, date_board.owed.size());
         end
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/gdau_pkg.sv
sv/gdau_if.sv
sv/gdau_ctrl.sv
sv/gdau_datapath.sv
sv/gregorian_date_arithmetic_unit.sv
verif/gregorian_date_arithmetic_unit_test.sv
